// ----- sv/ibf_pkg.sv -----
// Shared types and constants for the fourth-order band-pass IIR filter.
// No dependencies; every other file of the block imports this package.
package ibf_pkg;

  // Field widths and fixed-point formats.
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned COEF_W    = 32;
  localparam int unsigned OUT_W     = 32;
  localparam int unsigned COEF_FRAC = 28;
  localparam int unsigned ACC_W     = 68;
  localparam int unsigned DIFF_W    = SAMPLE_W + 3;
  localparam int unsigned NUM_W     = COEF_W + DIFF_W;
  localparam int unsigned NUM_CELLS = 4;
  localparam int unsigned CFG_IDX_W = 3;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [OUT_W-1:0]  out_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_GAIN = 3'd0,
    REG_FB_A1    = 3'd1,
    REG_FB_A2    = 3'd2,
    REG_FB_A3    = 3'd3,
    REG_FB_A4    = 3'd4
  } cfg_reg_e;

  // Coefficient values after reset, signed Q3.28.
  localparam coef_t RST_NUM_GAIN = 32'sd8040871;
  localparam coef_t RST_FB_A1    = -32'sd858565082;
  localparam coef_t RST_FB_A2    = 32'sd1087318467;
  localparam coef_t RST_FB_A3    = -32'sd646828092;
  localparam coef_t RST_FB_A4    = 32'sd154098573;

  // Half of one output LSB in the accumulator format.
  localparam acc_t ROUND_HALF = acc_t'(1) <<< (COEF_FRAC - 1);

  localparam out_t OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam out_t OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // Control that the head of the chain hands to every cell.
  typedef struct packed {
    logic enable;
    logic clear;
  } cell_ctrl_t;

endpackage

// ----- sv/ibf_if.sv -----
// Channel interfaces of the band-pass filter: sample input, filtered result
// and configuration writes. Depends on ibf_pkg.
interface ibf_sample_if import ibf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_in;
  logic                block_start;

  modport source (output valid, sample_in, block_start, input ready);
  modport sink   (input valid, sample_in, block_start, output ready);
endinterface

interface ibf_result_if import ibf_pkg::*; ();
  logic       valid;
  logic       ready;
  out_t       filtered_out;
  logic       saturated;

  modport source (output valid, filtered_out, saturated, input ready);
  modport sink   (input valid, filtered_out, saturated, output ready);
endinterface

interface ibf_cfg_if import ibf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COEF_W-1:0]    wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

// ----- sv/ibf_cell.sv -----
// One tap of the direct-form history chain: holds a past sample and a past
// output, hands both to the next tap each accepted word and forms its
// feedback product. Depends on ibf_pkg.
module ibf_cell import ibf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cell_ctrl_t          ctrl_i,
  input  coef_t               coef_i,
  input  logic [SAMPLE_W-1:0] x_i,
  input  out_t                y_i,
  output logic [SAMPLE_W-1:0] x_o,
  output out_t                y_o,
  output acc_t                fb_o
);

  logic signed [COEF_W+OUT_W-1:0] prod;
  logic [SAMPLE_W-1:0]            x_d;
  logic [SAMPLE_W-1:0]            x_q;
  out_t                           y_d;
  out_t                           y_q;

  // A block start empties the older taps while the new pair shifts in.
  always_comb begin
    x_d = ctrl_i.clear ? '0 : x_i;
    y_d = ctrl_i.clear ? '0 : y_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
    end else if (ctrl_i.enable) begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  // Feedback term of this tap, negated and kept exact.
  assign prod = coef_i * y_q;
  assign fb_o = -(acc_t'(prod));

  assign x_o = x_q;
  assign y_o = y_q;

endmodule

// ----- sv/iir_bandpass_filter.sv -----
// Fourth-order band-pass IIR filter in direct form I: one sample word is
// accepted per clock cycle while results are taken, and its result passes through
// one input register and one output register, so words can follow
// back to back. The rate is set by the feedback loop: the output history feeds
// four 32x32 coefficient multipliers whose products, together with the
// numerator term b0*(x[n] - 2x[n-2] + x[n-4]), are summed exactly, rounded half
// up once, clamped to 32 bits and shifted back into the history in the same cycle.
// The input stalls only while both registers hold words and the result is not
// taken. A block start clears both histories before its own sample is used.
// Write coefficients only while no word is in flight; the block does not enforce
// this; histories are kept across writes. Depends on ibf_pkg, ibf_if, ibf_cell.
module iir_bandpass_filter import ibf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  ibf_sample_if.sink          sample_i,
  ibf_result_if.source        result_o,
  ibf_cfg_if.sink             cfg_i
);

  localparam int unsigned YW_W = ACC_W - COEF_FRAC;

  coef_t                    num_gain_q;
  coef_t                    fb_a_q [NUM_CELLS];

  logic                     v0_q;
  logic                     clr0_q;
  logic [SAMPLE_W-1:0]      x0_q;

  logic                     out_valid_q;
  out_t                     y_q;
  logic                     sat_q;

  logic                     move;
  logic [SAMPLE_W-1:0]      x_n2;
  logic [SAMPLE_W-1:0]      x_n4;
  logic signed [DIFF_W-1:0] diff;
  logic signed [NUM_W-1:0]  num_prod;
  acc_t                     head_sum;
  acc_t                     head_rnd;
  logic signed [YW_W-1:0]   yw;
  logic                     pos_ovf;
  logic                     neg_ovf;
  out_t                     y_sat;
  logic                     sat_d;

  logic [SAMPLE_W-1:0]      cell_x  [NUM_CELLS];
  out_t                     cell_y  [NUM_CELLS];
  acc_t                     cell_fb [NUM_CELLS];

  // Configuration writes; indexes past the last register are dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_gain_q <= RST_NUM_GAIN;
      fb_a_q[0]  <= RST_FB_A1;
      fb_a_q[1]  <= RST_FB_A2;
      fb_a_q[2]  <= RST_FB_A3;
      fb_a_q[3]  <= RST_FB_A4;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_NUM_GAIN: num_gain_q <= coef_t'(cfg_i.wdata);
        REG_FB_A1:    fb_a_q[0]  <= coef_t'(cfg_i.wdata);
        REG_FB_A2:    fb_a_q[1]  <= coef_t'(cfg_i.wdata);
        REG_FB_A3:    fb_a_q[2]  <= coef_t'(cfg_i.wdata);
        REG_FB_A4:    fb_a_q[3]  <= coef_t'(cfg_i.wdata);
        default: ;
      endcase
    end
  end

  // Handshake: the input stage advances whenever its word can move on.
  assign move           = v0_q && (!out_valid_q || result_o.ready);
  assign sample_i.ready = !v0_q || move;

  // Input stage: hold the new sample and its block start flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (sample_i.ready) begin
      v0_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.valid && sample_i.ready) begin
      x0_q   <= sample_i.sample_in;
      clr0_q <= sample_i.block_start;
    end
  end

  // Head of the chain: exact sum, round half up, clamp to the output field.
  always_comb begin
    x_n2     = clr0_q ? '0 : cell_x[1];
    x_n4     = clr0_q ? '0 : cell_x[3];
    diff     = $signed({{(DIFF_W-SAMPLE_W){1'b0}}, x0_q})
             - ($signed({{(DIFF_W-SAMPLE_W){1'b0}}, x_n2}) <<< 1)
             + $signed({{(DIFF_W-SAMPLE_W){1'b0}}, x_n4});
    num_prod = num_gain_q * diff;
    head_sum = acc_t'(num_prod);
    for (int k = 0; k < NUM_CELLS; k++) begin
      if (!clr0_q) begin
        head_sum = head_sum + cell_fb[k];
      end
    end
    head_rnd = head_sum + ROUND_HALF;
    yw       = $signed(head_rnd[ACC_W-1:COEF_FRAC]);
    pos_ovf  = !yw[YW_W-1] && (|yw[YW_W-2:OUT_W-1]);
    neg_ovf  = yw[YW_W-1] && !(&yw[YW_W-2:OUT_W-1]);
    sat_d    = pos_ovf || neg_ovf;
    if (pos_ovf) begin
      y_sat = OUT_MAX;
    end else if (neg_ovf) begin
      y_sat = OUT_MIN;
    end else begin
      y_sat = yw[OUT_W-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || result_o.ready) begin
      out_valid_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      y_q   <= y_sat;
      sat_q <= sat_d;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.filtered_out = y_q;
  assign result_o.saturated    = sat_q;

  // Chain of cells: tap k holds x[n-1-k] and y[n-1-k] and passes them on.
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    logic [SAMPLE_W-1:0] x_in;
    out_t                y_in;
    cell_ctrl_t          ctrl;
    if (k == 0) begin : g_head
      assign x_in = x0_q;
      assign y_in = y_sat;
      assign ctrl = '{enable: move, clear: 1'b0};
    end else begin : g_link
      assign x_in = cell_x[k-1];
      assign y_in = cell_y[k-1];
      assign ctrl = '{enable: move, clear: clr0_q};
    end

    ibf_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .coef_i (fb_a_q[k]),
      .x_i    (x_in),
      .y_i    (y_in),
      .x_o    (cell_x[k]),
      .y_o    (cell_y[k]),
      .fb_o   (cell_fb[k])
    );
  end

  // The input only stalls when both stages hold words that cannot drain.
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sample_i.ready |-> (v0_q && out_valid_q && !result_o.ready))
    else $error("input stalled while the pipeline could advance");

  // Filter state changes only when a word moves into the output register.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !move |=> $stable(cell_x[0]) && $stable(cell_y[3]))
    else $error("filter state changed without a word moving");

  // A clipped result sits at one of the field limits.
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && sat_q) |-> (y_q == OUT_MAX || y_q == OUT_MIN))
    else $error("saturated flag set on an unclipped result");

endmodule
